// ===== design/sbc_pkg.sv =====
// Package: shared types, codes and constants of the stereo bitcrusher.
package sbc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int HOLD_W     = 7;
  localparam int QBITS_W    = 5;
  localparam int COUNT_W    = 8;

  localparam logic [QBITS_W-1:0] QBITS_MIN = QBITS_W'(4);
  localparam logic [QBITS_W-1:0] QBITS_MAX = QBITS_W'(16);

  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD   = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_QBITS  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA  = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_MIX    = CFG_ADDR_W'(4);

  localparam logic [HOLD_W-1:0]  HOLD_RST  = HOLD_W'(1);
  localparam logic [QBITS_W-1:0] QBITS_RST = QBITS_W'(16);

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_QNT,
    ALU_MUL,
    ALU_ACC
  } alu_op_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_HOLD,
    SQ_MULA,
    SQ_ACCA,
    SQ_MULM,
    SQ_ACCM,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    alu_op_t op;
    logic    ch;
    logic    hold_we;
    logic    smooth_we;
    logic    y_we;
    logic    use_mix;
    logic    out_load;
  } seq_ctl_t;

endpackage

// ===== design/sbc_alu.sv =====
// Shared arithmetic unit: quantizer, coefficient multiply and round-accumulate-saturate.
module sbc_alu
  import sbc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                          clk,
  input  alu_op_t                       op,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  input  logic        [COEF_BITS:0]     coef,
  input  logic        [QBITS_W-1:0]     quant_bits,
  output logic signed [SAMPLE_BITS-1:0] res
);

  localparam int S   = SAMPLE_BITS;
  localparam int C   = COEF_BITS;
  localparam int DW  = S + 1;
  localparam int PW  = C + 2 + DW;
  localparam int SW  = PW - C;
  localparam int UW  = SW + 1;
  localparam int SHW = $clog2(S);

  localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << (C - 1));
  localparam logic signed [UW-1:0] SMAX_U   = UW'((64'd1 << (S - 1)) - 64'd1);
  localparam logic signed [UW-1:0] SMIN_U   = -SMAX_U - UW'(1);
  localparam logic signed [S+1:0]  SMAX_Q   = (S+2)'((64'd1 << (S - 1)) - 64'd1);

  logic signed [DW-1:0]  diff;
  logic signed [C+1:0]   coef_s;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  rnd;
  logic signed [SW-1:0]  scl;
  logic signed [UW-1:0]  sum;
  logic signed [S-1:0]   acc_res;

  logic [QBITS_W-1:0]    qb;
  logic signed [6:0]     sh_full;
  logic [SHW-1:0]        sh;
  logic [S:0]            mag;
  logic [S:0]            half;
  logic [S:0]            mmask;
  logic [S:0]            rmag;
  logic signed [S+1:0]   qv;
  logic signed [S-1:0]   q_res;

  assign diff   = $signed({a[S-1], a}) - $signed({b[S-1], b});
  assign coef_s = $signed({1'b0, coef});

  always_ff @(posedge clk) begin
    if (op == ALU_MUL) begin
      prod_r <= PW'(coef_s) * PW'(diff);
    end
  end

  always_comb begin
    rnd = prod_r + RND_HALF;
    scl = SW'(rnd >>> C);
    sum = UW'(a) + UW'(scl);
    if (sum > SMAX_U) begin
      acc_res = SMAX_U[S-1:0];
    end else if (sum < SMIN_U) begin
      acc_res = SMIN_U[S-1:0];
    end else begin
      acc_res = sum[S-1:0];
    end
  end

  always_comb begin
    if (quant_bits < QBITS_MIN) begin
      qb = QBITS_MIN;
    end else if (quant_bits > QBITS_MAX) begin
      qb = QBITS_MAX;
    end else begin
      qb = quant_bits;
    end
    sh_full = $signed(7'(S)) - $signed({2'b00, qb});
    sh      = sh_full[SHW-1:0];
    mag     = a[S-1] ? (S+1)'(-$signed({a[S-1], a})) : {1'b0, a};
    half    = (S+1)'(1) << (sh - SHW'(1));
    mmask   = ~(((S+1)'(1) << sh) - (S+1)'(1));
    rmag    = (mag + half) & mmask;
    qv      = a[S-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    if (sh_full <= 7'sd0) begin
      q_res = a;
    end else if (qv > SMAX_Q) begin
      q_res = SMAX_Q[S-1:0];
    end else begin
      q_res = qv[S-1:0];
    end
  end

  always_comb begin
    unique case (op)
      ALU_QNT: res = q_res;
      ALU_ACC: res = acc_res;
      default: res = a;
    endcase
  end

endmodule

// ===== design/sbc_seq.sv =====
// Sequencer: steps the shared unit through both channels if enabled.
module sbc_seq
  import sbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     enable,
  input  logic     out_free,
  output logic     in_ready,
  output seq_ctl_t ctl
);

  seq_state_t state_r, state_nxt;
  logic       ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.op        = ALU_NOP;
    ctl.ch        = ch_r;
    unique case (state_r)
      SQ_IDLE: begin
        in_ready = 1'b1;
        ch_nxt   = 1'b0;
        if (in_fire) begin
          state_nxt = enable ? SQ_HOLD : SQ_DONE;
        end
      end
      SQ_HOLD: begin
        ctl.op      = ALU_QNT;
        ctl.hold_we = 1'b1;
        state_nxt   = SQ_MULA;
      end
      SQ_MULA: begin
        ctl.op    = ALU_MUL;
        state_nxt = SQ_ACCA;
      end
      SQ_ACCA: begin
        ctl.op        = ALU_ACC;
        ctl.smooth_we = 1'b1;
        state_nxt     = SQ_MULM;
      end
      SQ_MULM: begin
        ctl.op      = ALU_MUL;
        ctl.use_mix = 1'b1;
        state_nxt   = SQ_ACCM;
      end
      SQ_ACCM: begin
        ctl.op      = ALU_ACC;
        ctl.use_mix = 1'b1;
        ctl.y_we    = 1'b1;
        ch_nxt      = ~ch_r;
        state_nxt   = ch_r ? SQ_DONE : SQ_HOLD;
      end
      SQ_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

endmodule

// ===== design/stereo_bitcrusher_with_lowpass.sv =====
// Top level: stereo bitcrusher with sample-and-hold, quantizer and one-pole lowpass.
//
//   channel  direction  handshake         payload
//   in_      slave      tvalid / tready   tdata: left_sample, right_sample
//   out_     master     tvalid / tready   tdata: left_out, right_out
//   cfg_     write      we                addr, wdata
//
// Enabled item: for each channel in turn the sequencer runs five steps of the shared unit (hold,
// smoothing multiply and accumulate, mix multiply and accumulate), then loads the result.
// Bypassed item: goes from accept straight to the result load. Each item is loaded before the next is accepted.
// A result waits in the output register; a stalled output holds the next item at its last step.
// Synchronous reset sets configuration to its defaults and clears hold counters, held and filter values.
module stereo_bitcrusher_with_lowpass
  import sbc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  parameter int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [TDATA_W-1:0]      in_tdata,   // left_sample, right_sample
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // left_out, right_out
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [COEF_BITS:0]      cfg_wdata
);

  localparam int S = SAMPLE_BITS;
  localparam int C = COEF_BITS;
  localparam logic [C:0] COEF_ONE = (C+1)'(1) << C;

  logic                  enable_r;
  logic [HOLD_W-1:0]     hold_r;
  logic [QBITS_W-1:0]    qbits_r;
  logic [C:0]            alpha_r;
  logic [C:0]            mix_r;

  logic [COUNT_W-1:0]    count_r  [2];
  logic signed [S-1:0]   held_r   [2];
  logic signed [S-1:0]   smooth_r [2];
  logic signed [S-1:0]   x_r      [2];
  logic signed [S-1:0]   y_r      [2];

  logic                  out_valid_r;
  logic [TDATA_W-1:0]    out_data_r;

  seq_ctl_t              ctl;
  logic                  in_fire;
  logic                  out_free;
  logic [C:0]            alpha_c;
  logic [C:0]            mix_c;
  logic signed [S-1:0]   alu_a;
  logic signed [S-1:0]   alu_b;
  logic [C:0]            alu_coef;
  logic signed [S-1:0]   alu_res;

  assign in_fire  = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;
  assign alpha_c  = (alpha_r > COEF_ONE) ? COEF_ONE : alpha_r;
  assign mix_c    = (mix_r > COEF_ONE) ? COEF_ONE : mix_r;

  always_comb begin
    alu_coef = ctl.use_mix ? mix_c : alpha_c;
    alu_b    = ctl.use_mix ? x_r[ctl.ch] : smooth_r[ctl.ch];
    if (ctl.op == ALU_QNT) begin
      alu_a = x_r[ctl.ch];
    end else if (ctl.use_mix) begin
      alu_a = (ctl.op == ALU_MUL) ? smooth_r[ctl.ch] : x_r[ctl.ch];
    end else begin
      alu_a = (ctl.op == ALU_MUL) ? held_r[ctl.ch] : smooth_r[ctl.ch];
    end
  end

  sbc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .enable   (enable_r),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  sbc_alu #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_alu (
    .clk        (clk),
    .op         (ctl.op),
    .a          (alu_a),
    .b          (alu_b),
    .coef       (alu_coef),
    .quant_bits (qbits_r),
    .res        (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      hold_r   <= HOLD_RST;
      qbits_r  <= QBITS_RST;
      alpha_r  <= COEF_ONE;
      mix_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_HOLD:   hold_r   <= cfg_wdata[HOLD_W-1:0];
        CFG_QBITS:  qbits_r  <= cfg_wdata[QBITS_W-1:0];
        CFG_ALPHA:  alpha_r  <= cfg_wdata;
        CFG_MIX:    mix_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r[0]  <= '0;
      count_r[1]  <= '0;
      held_r[0]   <= '0;
      held_r[1]   <= '0;
      smooth_r[0] <= '0;
      smooth_r[1] <= '0;
    end else begin
      if (ctl.hold_we) begin
        if (count_r[ctl.ch] == '0) begin
          held_r[ctl.ch]  <= alu_res;
          count_r[ctl.ch] <= COUNT_W'(hold_r);
        end else begin
          count_r[ctl.ch] <= count_r[ctl.ch] - COUNT_W'(1);
        end
      end
      if (ctl.smooth_we) begin
        smooth_r[ctl.ch] <= alu_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r[0] <= in_tdata[S-1:0];
      x_r[1] <= in_tdata[2*S-1:S];
      y_r[0] <= in_tdata[S-1:0];
      y_r[1] <= in_tdata[2*S-1:S];
    end else if (ctl.y_we) begin
      y_r[ctl.ch] <= alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= TDATA_W'({y_r[1], y_r[0]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
